// File: design/blwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blwm_pkg: shared types and constants of the bootloader write host
// Item and burst layouts, protocol bytes and the byte checksum helper.
// ----------------------------------------------------------------------------
package blwm_pkg;

   // step size of one programmed word
   localparam int unsigned WORD_BYTES = 4;

   // protocol bytes
   localparam logic [7:0] ACK_BYTE      = 8'h79;
   localparam logic [7:0] SYNC_BYTE     = 8'h7F;
   localparam logic [7:0] CMD_WRITE     = 8'h31;
   localparam logic [7:0] CMD_WRITE_INV = 8'hCE;
   localparam logic [7:0] COUNT_BYTE    = 8'(WORD_BYTES - 1);

   // reset value of the base address register
   localparam logic [31:0] BASE_RESET = 32'h0800_0000;

   // input item kinds
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_WORD  = 2'd1;
   localparam logic [1:0] KIND_REPLY = 2'd2;

   // result status codes
   localparam logic [2:0] ST_BUSY  = 3'd0;
   localparam logic [2:0] ST_READY = 3'd1;
   localparam logic [2:0] ST_DONE  = 3'd2;
   localparam logic [2:0] ST_ABORT = 3'd3;
   localparam logic [2:0] ST_BAD   = 3'd4;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ADDRESS = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_BYTES  = 8'd1;

   // most results one item can cause
   localparam int unsigned BURST_MAX = 6;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] word;
      logic [7:0]  reply_byte;
   } item_type;

   // results of one item, slot 0 goes out first
   typedef struct packed {
      logic [2:0]                count;
      logic [BURST_MAX-1:0]      has;
      logic [BURST_MAX-1:0][7:0] bytes;
      logic [2:0]                status;
   } burst_type;

   // xor of the four bytes of a word
   function automatic logic [7:0] xor_bytes(input logic [31:0] w);
      xor_bytes = w[31:24] ^ w[23:16] ^ w[15:8] ^ w[7:0];
   endfunction

endpackage

// File: design/blwm_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blwm_step: exchange sequencer of the bootloader write host
// Holds the exchange phase, address, word and byte tally, and turns one
// item into the burst of bytes it causes.
// ----------------------------------------------------------------------------
module blwm_step (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  blwm_pkg::item_type   item,
   input  logic [31:0]          base_address,
   input  logic [31:0]          image_bytes,
   output blwm_pkg::burst_type  burst
);

   // exchange phases
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_SYNC  = 3'd1;
   localparam logic [2:0] PH_READY = 3'd2;
   localparam logic [2:0] PH_CMD   = 3'd3;
   localparam logic [2:0] PH_ADDR  = 3'd4;
   localparam logic [2:0] PH_DATA  = 3'd5;
   localparam logic [2:0] PH_DONE  = 3'd6;
   localparam logic [2:0] PH_ABORT = 3'd7;

   logic [2:0]  phase_ff, phase_in;
   logic [31:0] address_ff, address_in;
   logic [31:0] held_ff, held_in;
   logic [31:0] written_ff, written_in;
   logic [32:0] written_sum;
   logic [31:0] written_step;

   // saturating tally step
   assign written_sum  = {1'b0, written_ff} + 33'(blwm_pkg::WORD_BYTES);
   assign written_step = written_sum[32] ? 32'hFFFF_FFFF : written_sum[31:0];

   // phase decode and burst build
   always_comb begin
      phase_in     = phase_ff;
      address_in   = address_ff;
      held_in      = held_ff;
      written_in   = written_ff;
      burst        = '0;
      burst.count  = 3'd1;
      burst.status = blwm_pkg::ST_BAD;
      unique case (item.kind)
         blwm_pkg::KIND_START: begin
            if (phase_ff == PH_IDLE || phase_ff == PH_DONE || phase_ff == PH_ABORT) begin
               address_in     = base_address;
               written_in     = '0;
               phase_in       = PH_SYNC;
               burst.has[0]   = 1'b1;
               burst.bytes[0] = blwm_pkg::SYNC_BYTE;
               burst.status   = blwm_pkg::ST_BUSY;
            end
         end
         blwm_pkg::KIND_WORD: begin
            if (phase_ff == PH_READY) begin
               held_in        = item.word;
               phase_in       = PH_CMD;
               burst.count    = 3'd2;
               burst.has[1:0] = 2'b11;
               burst.bytes[0] = blwm_pkg::CMD_WRITE;
               burst.bytes[1] = blwm_pkg::CMD_WRITE_INV;
               burst.status   = blwm_pkg::ST_BUSY;
            end
         end
         blwm_pkg::KIND_REPLY: begin
            if (phase_ff == PH_SYNC) begin
               // sync reply is taken unchecked
               if (written_ff >= image_bytes) begin
                  phase_in     = PH_DONE;
                  burst.status = blwm_pkg::ST_DONE;
               end else begin
                  phase_in     = PH_READY;
                  burst.status = blwm_pkg::ST_READY;
               end
            end else if (phase_ff == PH_CMD || phase_ff == PH_ADDR ||
                         phase_ff == PH_DATA) begin
               if (item.reply_byte != blwm_pkg::ACK_BYTE) begin
                  phase_in     = PH_ABORT;
                  burst.status = blwm_pkg::ST_ABORT;
               end else if (phase_ff == PH_CMD) begin
                  // address bytes, msb first, then checksum
                  burst.count    = 3'd5;
                  burst.has[4:0] = 5'b11111;
                  burst.bytes[0] = address_ff[31:24];
                  burst.bytes[1] = address_ff[23:16];
                  burst.bytes[2] = address_ff[15:8];
                  burst.bytes[3] = address_ff[7:0];
                  burst.bytes[4] = blwm_pkg::xor_bytes(address_ff);
                  phase_in       = PH_ADDR;
                  burst.status   = blwm_pkg::ST_BUSY;
               end else if (phase_ff == PH_ADDR) begin
                  // count byte, data bytes, checksum
                  burst.count    = 3'd6;
                  burst.has      = '1;
                  burst.bytes[0] = blwm_pkg::COUNT_BYTE;
                  burst.bytes[1] = held_ff[31:24];
                  burst.bytes[2] = held_ff[23:16];
                  burst.bytes[3] = held_ff[15:8];
                  burst.bytes[4] = held_ff[7:0];
                  burst.bytes[5] = blwm_pkg::xor_bytes(held_ff) ^ blwm_pkg::COUNT_BYTE;
                  phase_in       = PH_DATA;
                  burst.status   = blwm_pkg::ST_BUSY;
               end else begin
                  // word acknowledged
                  address_in = address_ff + 32'(blwm_pkg::WORD_BYTES);
                  written_in = written_step;
                  if (written_step >= image_bytes) begin
                     phase_in     = PH_DONE;
                     burst.status = blwm_pkg::ST_DONE;
                  end else begin
                     phase_in     = PH_READY;
                     burst.status = blwm_pkg::ST_READY;
                  end
               end
            end
         end
         default: begin
            burst.status = blwm_pkg::ST_BAD;
         end
      endcase
   end

   // exchange state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         address_ff <= blwm_pkg::BASE_RESET;
         held_ff    <= '0;
         written_ff <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         address_ff <= address_in;
         held_ff    <= held_in;
         written_ff <= written_in;
      end
   end

endmodule

// File: design/blwm_burst.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blwm_burst: result buffer of the bootloader write host
// Holds the bytes of one item and hands them out one word per cycle while rsp_tready is high.
// ----------------------------------------------------------------------------
module blwm_burst (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  blwm_pkg::burst_type  burst,
   output logic                 can_load,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic                 rsp_has_byte,
   output logic [7:0]           rsp_tx_byte,
   output logic [2:0]           rsp_status,
   output logic                 rsp_last
);

   logic [2:0]                          count_ff, count_in;
   logic [blwm_pkg::BURST_MAX-1:0]      has_ff, has_in;
   logic [blwm_pkg::BURST_MAX-1:0][7:0] bytes_ff, bytes_in;
   logic [2:0]                          status_ff;
   logic                                take;

   assign rsp_tvalid   = (count_ff != 3'd0);
   assign take         = rsp_tvalid && rsp_tready;
   assign can_load     = (count_ff == 3'd0) || (count_ff == 3'd1 && rsp_tready);
   assign rsp_has_byte = has_ff[0];
   assign rsp_tx_byte  = bytes_ff[0];
   assign rsp_status   = status_ff;
   assign rsp_last     = (count_ff == 3'd1);

   // load a new burst or shift out the head word
   always_comb begin
      count_in = count_ff;
      has_in   = has_ff;
      bytes_in = bytes_ff;
      if (load) begin
         count_in = burst.count;
         has_in   = burst.has;
         bytes_in = burst.bytes;
      end else if (take) begin
         count_in = count_ff - 3'd1;
         has_in   = {1'b0, has_ff[blwm_pkg::BURST_MAX-1:1]};
         bytes_in = {8'h00, bytes_ff[blwm_pkg::BURST_MAX-1:1]};
      end
   end

   // buffer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      has_ff   <= has_in;
      bytes_ff <= bytes_in;
      if (load) begin
         status_ff <= burst.status;
      end
   end

endmodule

// File: design/bootloader_write_memory_host.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bootloader_write_memory_host: host side of a serial bootloader write
// Runs sync, write command, address and data handshakes, one word per item.
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  req_     in         tuser kind, tdata word and reply byte
//  rsp_     out        tuser has_byte, tdata tx byte and status, tlast
//  csr_     in         register index and write data
//
// an item is held in the input register, then its burst is loaded into the
// result buffer, which hands out one result word per cycle while rsp_tready is high
// an item causes one to six results, and the result buffer alone sets the sustained rate
// reset clears the exchange phase and buffer counts
// a stalled rsp_ side holds the buffer, and the input register then holds
// one further item
module bootloader_write_memory_host (
   input  logic                             clock,
   input  logic                             reset,
   // input channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [39:0]                      req_tdata,   // word[31:0], reply_byte[39:32]
   input  logic [1:0]                       req_tuser,   // kind[1:0]
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [15:0]                      rsp_tdata,   // tx_byte[7:0], status[10:8], zero
   output logic                             rsp_tuser,   // has_byte
   output logic                             rsp_tlast,
   // configuration port
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [blwm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                      csr_data
);

   logic                item_valid_ff, item_valid_in;
   blwm_pkg::item_type  item_ff;
   blwm_pkg::burst_type burst;
   logic [31:0]         base_ff, image_ff;
   logic                can_load, load;
   logic                rsp_has_byte;
   logic [7:0]          rsp_tx_byte;
   logic [2:0]          rsp_status;

   assign csr_ready     = 1'b1;
   assign load          = item_valid_ff && can_load;
   assign req_tready    = !item_valid_ff || load;
   assign item_valid_in = (req_tvalid && req_tready) ? 1'b1 : (load ? 1'b0 : item_valid_ff);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= blwm_pkg::BASE_RESET;
         image_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            blwm_pkg::CSR_BASE_ADDRESS: base_ff  <= csr_data;
            blwm_pkg::CSR_IMAGE_BYTES:  image_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      if (req_tvalid && req_tready) begin
         item_ff.kind       <= req_tuser;
         item_ff.word       <= req_tdata[31:0];
         item_ff.reply_byte <= req_tdata[39:32];
      end
   end

   blwm_step u_step (
      .clock        (clock),
      .reset        (reset),
      .fire         (load),
      .item         (item_ff),
      .base_address (base_ff),
      .image_bytes  (image_ff),
      .burst        (burst)
   );

   blwm_burst u_burst (
      .clock        (clock),
      .reset        (reset),
      .load         (load),
      .burst        (burst),
      .can_load     (can_load),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_has_byte (rsp_has_byte),
      .rsp_tx_byte  (rsp_tx_byte),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_tlast)
   );

   // result word packing
   assign rsp_tdata = {5'b00000, rsp_status, rsp_tx_byte};
   assign rsp_tuser = rsp_has_byte;

endmodule
